### rtl/tpgc_pkg.sv
// ----------------------------------------------------------------------------
// tpgc_pkg
// Shared types, codes and constants of the two-player game clock.
// ----------------------------------------------------------------------------
package tpgc_pkg;

    localparam int NUM_CHOICES = 3;
    localparam int POT_BITS    = 10;
    localparam int POT_IN_W    = 10;
    localparam int SEC_W       = 16;
    localparam int OPT_W       = 2;

    localparam logic [SEC_W-1:0] TIME_A_RST = 16'd300;
    localparam logic [SEC_W-1:0] TIME_B_RST = 16'd180;
    localparam logic [SEC_W-1:0] TIME_C_RST = 16'd60;
    localparam logic [SEC_W-1:0] TPS_RST    = 16'd1000;
    localparam logic [OPT_W-1:0] OPT_RST    = (NUM_CHOICES > 1) ? 2'd1 : 2'd0;
    localparam logic [OPT_W-1:0] OPT_MAX    = OPT_W'(NUM_CHOICES - 1);

    // stream widths: tdata padded to whole bytes
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [1:0] {
        PH_SELECT = 2'd0,
        PH_ONE    = 2'd1,
        PH_TWO    = 2'd2,
        PH_OVER   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_P1   = 2'd1,
        CMD_P2   = 2'd2,
        CMD_POT  = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_A = 2'd0,
        CFG_TIME_B = 2'd1,
        CFG_TIME_C = 2'd2,
        CFG_TPS    = 2'd3
    } t_cfg_idx;

    localparam logic [1:0] WIN_NONE = 2'd0;
    localparam logic [1:0] WIN_ONE  = 2'd1;
    localparam logic [1:0] WIN_TWO  = 2'd2;

    typedef struct packed {
        logic [SEC_W-1:0] time_a;
        logic [SEC_W-1:0] time_b;
        logic [SEC_W-1:0] time_c;
        logic [SEC_W-1:0] ticks_per_second;
    } t_cfg;

    typedef struct packed {
        logic             changed;
        logic [OPT_W-1:0] option;
        logic [1:0]       winner;
        logic [SEC_W-1:0] p2_seconds;
        logic [SEC_W-1:0] p1_seconds;
        t_phase           phase;
    } t_result;

endpackage

### rtl/tpgc_cfg.sv
// ----------------------------------------------------------------------------
// tpgc_cfg
// Configuration registers: three preset durations and the second length.
// ----------------------------------------------------------------------------
module tpgc_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tpgc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tpgc_pkg::SEC_W-1:0]      i_cfg_data,
    output tpgc_pkg::t_cfg                  o_cfg
);

    tpgc_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_a           <= tpgc_pkg::TIME_A_RST;
            r_cfg.time_b           <= tpgc_pkg::TIME_B_RST;
            r_cfg.time_c           <= tpgc_pkg::TIME_C_RST;
            r_cfg.ticks_per_second <= tpgc_pkg::TPS_RST;
        end else if (i_cfg_valid) begin
            case (tpgc_pkg::t_cfg_idx'(i_cfg_index))
                tpgc_pkg::CFG_TIME_A: r_cfg.time_a           <= i_cfg_data;
                tpgc_pkg::CFG_TIME_B: r_cfg.time_b           <= i_cfg_data;
                tpgc_pkg::CFG_TIME_C: r_cfg.time_c           <= i_cfg_data;
                tpgc_pkg::CFG_TPS:    r_cfg.ticks_per_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

### rtl/tpgc_fsm.sv
// ----------------------------------------------------------------------------
// tpgc_fsm
// Game state and its combinational next-state update for one event.
// ----------------------------------------------------------------------------
module tpgc_fsm (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tpgc_pkg::t_cfg                  i_cfg,
    input  logic                            i_ev_valid,
    input  logic [1:0]                      i_ev_cmd,
    input  logic [tpgc_pkg::POT_IN_W-1:0]   i_ev_pot,
    output tpgc_pkg::t_result               o_result
);

    localparam int PROD_W = tpgc_pkg::POT_BITS + 2;

    tpgc_pkg::t_phase               r_phase,  n_phase;
    logic [tpgc_pkg::SEC_W-1:0]     r_first,  n_first;
    logic [tpgc_pkg::SEC_W-1:0]     r_second, n_second;
    logic [tpgc_pkg::SEC_W-1:0]     r_sub,    n_sub;
    logic [tpgc_pkg::OPT_W-1:0]     r_option, n_option;
    logic [1:0]                     r_winner, n_winner;
    logic                           n_changed;

    logic [tpgc_pkg::SEC_W-1:0]     w_dur;
    logic [tpgc_pkg::SEC_W-1:0]     w_sub_inc;
    logic [tpgc_pkg::SEC_W-1:0]     w_left;
    logic [tpgc_pkg::SEC_W-1:0]     w_left_dec;
    logic [PROD_W-1:0]              w_prod;
    logic [tpgc_pkg::OPT_W-1:0]     w_opt_raw;
    logic [tpgc_pkg::OPT_W-1:0]     w_opt;
    tpgc_pkg::t_phase               w_own;
    tpgc_pkg::t_phase               w_other;

    always_comb begin
        case (r_option)
            2'd0:    w_dur = i_cfg.time_a;
            2'd1:    w_dur = i_cfg.time_b;
            default: w_dur = i_cfg.time_c;
        endcase
    end

    assign w_sub_inc  = r_sub + 16'd1;
    assign w_left     = (r_phase == tpgc_pkg::PH_ONE) ? r_first : r_second;
    assign w_left_dec = (w_left != '0) ? w_left - 16'd1 : w_left;

    // option = pot * choices / 2^bits, clamped
    assign w_prod    = PROD_W'(i_ev_pot[tpgc_pkg::POT_BITS-1:0])
                     * PROD_W'(tpgc_pkg::NUM_CHOICES);
    assign w_opt_raw = w_prod[PROD_W-1:tpgc_pkg::POT_BITS];
    assign w_opt     = (w_opt_raw > tpgc_pkg::OPT_MAX) ? tpgc_pkg::OPT_MAX : w_opt_raw;

    assign w_own   = (tpgc_pkg::t_cmd'(i_ev_cmd) == tpgc_pkg::CMD_P1) ?
                     tpgc_pkg::PH_ONE : tpgc_pkg::PH_TWO;
    assign w_other = (tpgc_pkg::t_cmd'(i_ev_cmd) == tpgc_pkg::CMD_P1) ?
                     tpgc_pkg::PH_TWO : tpgc_pkg::PH_ONE;

    always_comb begin
        n_phase   = r_phase;
        n_first   = r_first;
        n_second  = r_second;
        n_sub     = r_sub;
        n_option  = r_option;
        n_winner  = r_winner;
        n_changed = 1'b0;
        case (tpgc_pkg::t_cmd'(i_ev_cmd))
            tpgc_pkg::CMD_TICK: begin
                if (r_phase == tpgc_pkg::PH_ONE || r_phase == tpgc_pkg::PH_TWO) begin
                    n_sub = w_sub_inc;
                    // a second length of zero makes every tick a second
                    if (w_sub_inc >= i_cfg.ticks_per_second) begin
                        n_sub     = '0;
                        n_changed = 1'b1;
                        if (r_phase == tpgc_pkg::PH_ONE) begin
                            n_first = w_left_dec;
                        end else begin
                            n_second = w_left_dec;
                        end
                        if (w_left_dec == '0) begin
                            n_phase  = tpgc_pkg::PH_OVER;
                            n_winner = (r_phase == tpgc_pkg::PH_ONE) ?
                                       tpgc_pkg::WIN_TWO : tpgc_pkg::WIN_ONE;
                        end
                    end
                end
            end
            tpgc_pkg::CMD_P1, tpgc_pkg::CMD_P2: begin
                if (r_phase == w_own) begin
                    n_phase   = w_other;
                    n_sub     = '0;
                    n_changed = 1'b1;
                end else if (r_phase == tpgc_pkg::PH_SELECT) begin
                    n_first   = w_dur;
                    n_second  = w_dur;
                    n_phase   = w_other;
                    n_sub     = '0;
                    n_changed = 1'b1;
                end else if (r_phase == tpgc_pkg::PH_OVER) begin
                    n_first   = w_dur;
                    n_second  = w_dur;
                    n_phase   = tpgc_pkg::PH_SELECT;
                    n_winner  = tpgc_pkg::WIN_NONE;
                    n_sub     = '0;
                    n_changed = 1'b1;
                end
            end
            tpgc_pkg::CMD_POT: begin
                if (r_phase == tpgc_pkg::PH_SELECT && w_opt != r_option) begin
                    n_option  = w_opt;
                    n_changed = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= tpgc_pkg::PH_SELECT;
            r_first  <= tpgc_pkg::TIME_B_RST;
            r_second <= tpgc_pkg::TIME_B_RST;
            r_sub    <= '0;
            r_option <= tpgc_pkg::OPT_RST;
            r_winner <= tpgc_pkg::WIN_NONE;
        end else if (i_ev_valid) begin
            r_phase  <= n_phase;
            r_first  <= n_first;
            r_second <= n_second;
            r_sub    <= n_sub;
            r_option <= n_option;
            r_winner <= n_winner;
        end
    end

    assign o_result.phase      = n_phase;
    assign o_result.p1_seconds = n_first;
    assign o_result.p2_seconds = n_second;
    assign o_result.winner     = n_winner;
    assign o_result.option     = n_option;
    assign o_result.changed    = n_changed;

    a_winner_iff_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_winner != tpgc_pkg::WIN_NONE) == (r_phase == tpgc_pkg::PH_OVER))
        else $error("winner set outside game over");

    a_sub_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == tpgc_pkg::PH_SELECT || r_phase == tpgc_pkg::PH_OVER) |-> (r_sub == '0))
        else $error("sub-second count left over while not running");

    a_option_only_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != tpgc_pkg::PH_SELECT) |=> $stable(r_option))
        else $error("option changed outside select phase");

endmodule

### rtl/two_player_game_clock.sv
// ----------------------------------------------------------------------------
// two_player_game_clock
// Chess-style countdown clock: events in, full clock state out per event.
// ----------------------------------------------------------------------------
//  channel   | direction | content
//  s_axis    | in        | tuser[1:0] cmd, tdata[9:0] pot_value
//  m_axis    | out       | tdata: phase, p1 seconds, p2 seconds, winner, option, changed
//  cfg       | in        | register index + 16-bit write data, always ready
//
//  An event passes the input register, then the state update into the output register.
//  One event per cycle sustained while the output is not stalled; the state registers feed back through the update.
//  A stalled output holds the input stage; both stages drain as the sink takes data.
//  Synchronous active-low reset restores the preset durations and select phase.
// ----------------------------------------------------------------------------
module two_player_game_clock (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [9:0] pot_value, [15:10] zero
    input  logic [tpgc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [1:0] phase, [17:2] player_one_seconds, [33:18] player_two_seconds,
    // [35:34] winner, [37:36] chosen_option, [38] display_changed, [39] zero
    output logic [tpgc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tpgc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tpgc_pkg::SEC_W-1:0]          i_cfg_data
);

    localparam int RES_W = $bits(tpgc_pkg::t_result);

    tpgc_pkg::t_cfg                 w_cfg;
    tpgc_pkg::t_result              w_result;

    logic                           r_in_valid;
    logic [1:0]                     r_in_cmd;
    logic [tpgc_pkg::POT_IN_W-1:0]  r_in_pot;
    logic                           r_out_valid;
    tpgc_pkg::t_result              r_out_data;
    logic                           w_advance;

    assign w_advance     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_advance;

    tpgc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    tpgc_fsm u_fsm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_ev_valid (r_in_valid && w_advance),
        .i_ev_cmd   (r_in_cmd),
        .i_ev_pot   (r_in_pot),
        .o_result   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd <= s_axis_tuser;
            r_in_pot <= s_axis_tdata[tpgc_pkg::POT_IN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_valid) begin
            r_out_data <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(tpgc_pkg::OUT_DATA_W - RES_W){1'b0}}, r_out_data};

    a_in_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_cmd)))
        else $error("pending request lost while output stalled");

    a_out_filled_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_advance) |=> r_out_valid)
        else $error("processed request produced no result");

    a_no_result_from_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_in_valid && w_advance) |=> !r_out_valid)
        else $error("result produced without a request");

endmodule

### dv/tb_two_player_game_clock.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_player_game_clock
// Self-checking bench for the game clock: events go in on the slave stream
// and every result on the master stream is checked field by field against
// an in-bench model of the clock state, with random gaps on both sides outside the steady run.
// ----------------------------------------------------------------------------
module tb_two_player_game_clock;

    localparam int CYCLE_LIMIT = 200000;
    localparam int GAP_PCT     = 23;

    typedef struct packed {
        tpgc_pkg::t_cmd cmd;
        logic [9:0]     pot;
    } t_clock_event;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [tpgc_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [1:0]                      s_axis_tuser  = tpgc_pkg::CMD_TICK;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [tpgc_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            i_cfg_valid   = 1'b0;
    logic                            o_cfg_ready;
    logic [tpgc_pkg::CFG_IDX_W-1:0]  i_cfg_index   = tpgc_pkg::CFG_TIME_A;
    logic [tpgc_pkg::SEC_W-1:0]      i_cfg_data    = '0;

    two_player_game_clock dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // register mirror
    logic [tpgc_pkg::SEC_W-1:0] dur_a   = tpgc_pkg::TIME_A_RST;
    logic [tpgc_pkg::SEC_W-1:0] dur_b   = tpgc_pkg::TIME_B_RST;
    logic [tpgc_pkg::SEC_W-1:0] dur_c   = tpgc_pkg::TIME_C_RST;
    logic [tpgc_pkg::SEC_W-1:0] sec_len = tpgc_pkg::TPS_RST;

    // clock state mirror
    tpgc_pkg::t_phase           game_phase = tpgc_pkg::PH_SELECT;
    logic [tpgc_pkg::SEC_W-1:0] p1_left    = tpgc_pkg::TIME_B_RST;
    logic [tpgc_pkg::SEC_W-1:0] p2_left    = tpgc_pkg::TIME_B_RST;
    logic [tpgc_pkg::SEC_W-1:0] sub_ticks  = '0;
    logic [tpgc_pkg::OPT_W-1:0] option_sel = tpgc_pkg::OPT_RST;
    logic [1:0]                 winner_sel = tpgc_pkg::WIN_NONE;

    t_clock_event       pending_events[$];
    tpgc_pkg::t_result  expected_readouts[$];
    int                 mismatches  = 0;
    int                 cycle_count = 0;
    logic               in_taken    = 1'b0;
    logic               steady      = 1'b0;

    function automatic void load_durations();
        logic [tpgc_pkg::SEC_W-1:0] d;
        case (option_sel)
            2'd0:    d = dur_a;
            2'd1:    d = dur_b;
            default: d = dur_c;
        endcase
        p1_left = d;
        p2_left = d;
    endfunction

    function automatic logic press_button(tpgc_pkg::t_phase own, tpgc_pkg::t_phase other);
        if (game_phase == own) begin
            game_phase = other;
            sub_ticks  = '0;
            return 1'b1;
        end
        if (game_phase == tpgc_pkg::PH_SELECT) begin
            load_durations();
            game_phase = other;
            sub_ticks  = '0;
            return 1'b1;
        end
        if (game_phase == tpgc_pkg::PH_OVER) begin
            game_phase = tpgc_pkg::PH_SELECT;
            winner_sel = tpgc_pkg::WIN_NONE;
            sub_ticks  = '0;
            load_durations();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // applies one event to the mirrored clock and returns the readout it causes
    function automatic tpgc_pkg::t_result advance_clock(tpgc_pkg::t_cmd cmd, logic [9:0] pot);
        tpgc_pkg::t_result r;
        logic              changed;
        int unsigned       pick;
        changed = 1'b0;
        case (cmd)
            tpgc_pkg::CMD_TICK: begin
                if (game_phase == tpgc_pkg::PH_ONE || game_phase == tpgc_pkg::PH_TWO) begin
                    sub_ticks = sub_ticks + 1'b1;
                    if (sub_ticks >= sec_len) begin
                        sub_ticks = '0;
                        changed   = 1'b1;
                        if (game_phase == tpgc_pkg::PH_ONE) begin
                            if (p1_left != 0) p1_left = p1_left - 1'b1;
                            if (p1_left == 0) begin
                                game_phase = tpgc_pkg::PH_OVER;
                                winner_sel = tpgc_pkg::WIN_TWO;
                            end
                        end else begin
                            if (p2_left != 0) p2_left = p2_left - 1'b1;
                            if (p2_left == 0) begin
                                game_phase = tpgc_pkg::PH_OVER;
                                winner_sel = tpgc_pkg::WIN_ONE;
                            end
                        end
                    end
                end
            end
            tpgc_pkg::CMD_P1: changed = press_button(tpgc_pkg::PH_ONE, tpgc_pkg::PH_TWO);
            tpgc_pkg::CMD_P2: changed = press_button(tpgc_pkg::PH_TWO, tpgc_pkg::PH_ONE);
            default: begin
                if (game_phase == tpgc_pkg::PH_SELECT) begin
                    pick = (int'(pot) * tpgc_pkg::NUM_CHOICES) >> tpgc_pkg::POT_BITS;
                    if (pick > tpgc_pkg::OPT_MAX) pick = tpgc_pkg::OPT_MAX;
                    if (pick != option_sel) begin
                        option_sel = tpgc_pkg::OPT_W'(pick);
                        changed    = 1'b1;
                    end
                end
            end
        endcase
        r.phase      = game_phase;
        r.p1_seconds = p1_left;
        r.p2_seconds = p2_left;
        r.winner     = winner_sel;
        r.option     = option_sel;
        r.changed    = changed;
        return r;
    endfunction

    function automatic void check_field(string label, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, label, want, got);
        end
    endfunction

    // stimulus driver and output backpressure, both change on the falling edge
    always @(negedge i_clk) begin : drive
        t_clock_event ev;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (pending_events.size() != 0 &&
                (steady || $urandom_range(0, 99) >= GAP_PCT)) begin
                ev = pending_events.pop_front();
                s_axis_tuser  <= ev.cmd;
                s_axis_tdata  <= {{(tpgc_pkg::IN_DATA_W-10){1'b0}}, ev.pot};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= steady || ($urandom_range(0, 99) >= GAP_PCT);
    end

    always @(posedge i_clk) begin : watch
        tpgc_pkg::t_result got;
        tpgc_pkg::t_result want;
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[$bits(tpgc_pkg::t_result)-1:0];
                if (expected_readouts.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, got %h", $time, got);
                end else begin
                    want = expected_readouts.pop_front();
                    check_field("phase", want.phase, got.phase);
                    check_field("player_one_seconds", want.p1_seconds, got.p1_seconds);
                    check_field("player_two_seconds", want.p2_seconds, got.p2_seconds);
                    check_field("winner", want.winner, got.winner);
                    check_field("chosen_option", want.option, got.option);
                    check_field("display_changed", want.changed, got.changed);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_readouts.push_back(
                    advance_clock(tpgc_pkg::t_cmd'(s_axis_tuser), s_axis_tdata[9:0]));
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_two_player_game_clock: FAIL");
            $finish;
        end
    end

    task automatic queue_event(tpgc_pkg::t_cmd cmd, logic [9:0] pot);
        t_clock_event ev;
        ev.cmd = cmd;
        ev.pot = pot;
        pending_events.push_back(ev);
    endtask

    // mostly ticks with presses mixed in; short durations make games end often
    task automatic queue_play(int n);
        int r;
        logic [9:0] pot;
        for (int k = 0; k < n; k++) begin
            r   = $urandom_range(0, 99);
            pot = 10'($urandom_range(0, 1023));
            if (r < 62)      queue_event(tpgc_pkg::CMD_TICK, pot);
            else if (r < 74) queue_event(tpgc_pkg::CMD_P1, pot);
            else if (r < 86) queue_event(tpgc_pkg::CMD_P2, pot);
            else             queue_event(tpgc_pkg::CMD_POT, pot);
        end
    endtask

    task automatic wait_until_drained();
        while (pending_events.size() != 0 || s_axis_tvalid ||
               expected_readouts.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_register(tpgc_pkg::t_cfg_idx idx,
                                    logic [tpgc_pkg::SEC_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            tpgc_pkg::CFG_TIME_A: dur_a   = val;
            tpgc_pkg::CFG_TIME_B: dur_b   = val;
            tpgc_pkg::CFG_TIME_C: dur_c   = val;
            tpgc_pkg::CFG_TPS:    sec_len = val;
        endcase
    endtask

    task automatic configure(logic [tpgc_pkg::SEC_W-1:0] a, logic [tpgc_pkg::SEC_W-1:0] b,
                             logic [tpgc_pkg::SEC_W-1:0] c, logic [tpgc_pkg::SEC_W-1:0] tps);
        program_register(tpgc_pkg::CFG_TIME_A, a);
        program_register(tpgc_pkg::CFG_TIME_B, b);
        program_register(tpgc_pkg::CFG_TIME_C, c);
        program_register(tpgc_pkg::CFG_TPS, tps);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: idle tick, then pot thresholds around each option edge
        queue_event(tpgc_pkg::CMD_TICK, 10'd0);
        queue_event(tpgc_pkg::CMD_POT, 10'd1023);
        queue_event(tpgc_pkg::CMD_POT, 10'd683);
        queue_event(tpgc_pkg::CMD_POT, 10'd682);
        queue_event(tpgc_pkg::CMD_POT, 10'd342);
        queue_event(tpgc_pkg::CMD_POT, 10'd341);
        queue_event(tpgc_pkg::CMD_POT, 10'd0);
        wait_until_drained();

        // zero duration on option 0, zero-length second, max duration on option 2
        configure(16'd0, 16'd2, 16'hFFFF, 16'd0);
        queue_event(tpgc_pkg::CMD_P2, 10'h3FF);
        queue_event(tpgc_pkg::CMD_TICK, 10'd0);   // running time already zero: game over
        queue_event(tpgc_pkg::CMD_TICK, 10'd0);   // tick after game over
        queue_event(tpgc_pkg::CMD_POT, 10'd1023); // ignored outside select
        queue_event(tpgc_pkg::CMD_P1, 10'd0);     // restart
        queue_event(tpgc_pkg::CMD_POT, 10'd1023);
        queue_event(tpgc_pkg::CMD_P2, 10'd0);
        queue_event(tpgc_pkg::CMD_P2, 10'd0);     // waiting player's button: ignored
        queue_event(tpgc_pkg::CMD_P1, 10'd0);     // own button passes the turn
        queue_event(tpgc_pkg::CMD_TICK, 10'd0);
        queue_event(tpgc_pkg::CMD_P2, 10'd0);
        queue_event(tpgc_pkg::CMD_TICK, 10'd0);
        queue_event(tpgc_pkg::CMD_POT, 10'd500);
        wait_until_drained();

        configure(16'd1, 16'd2, 16'd3, 16'd1);
        queue_play(150);
        wait_until_drained();

        configure(16'd5, 16'd3, 16'hFFFF, 16'd3);
        queue_play(150);
        wait_until_drained();

        configure(16'd2, 16'hFFFF, 16'd1, 16'hFFFF);
        queue_play(60);
        wait_until_drained();

        steady = 1'b1;
        configure(16'd4, 16'd1, 16'd7, 16'd2);
        queue_play(150);
        wait_until_drained();
        steady = 1'b0;

        configure(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                  16'($urandom_range(1, 6)), 16'($urandom_range(0, 5)));
        queue_play(170);
        wait_until_drained();

        if (mismatches == 0) begin
            $display("tb_two_player_game_clock: PASS");
        end else begin
            $display("tb_two_player_game_clock: FAIL");
        end
        $finish;
    end

endmodule
